### rtl/core/sine_taylor_series_macros.svh
// Assertion macros shared by the sine series block.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef SINE_TAYLOR_SERIES_MACROS_SVH
`define SINE_TAYLOR_SERIES_MACROS_SVH

`ifndef SYNTH
`define STS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STS_ASSERT_ALWAYS(lbl, cond, msg)
`define STS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/sts_pkg.sv
package sts_pkg;

  localparam int MAX_TERMS = 16;
  localparam int ANGLE_W   = 32;
  localparam int COUNT_W   = 5;
  localparam int OUT_W     = 32;
  localparam int K_W       = $clog2(MAX_TERMS + 1);
  localparam int T_W       = 34;            // term magnitude, Q.24
  localparam int CHUNK_W   = T_W / 2;       // narrow multiplier operand
  localparam int X2_W      = 32;            // wide multiplier operand
  localparam int MUL_W     = X2_W + CHUNK_W;
  localparam int PROD_W    = 64;
  localparam int NUM_W     = PROD_W - 24;   // dividend width
  localparam int ACC_W     = 40;
  localparam int D_W       = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
  localparam int DIV_BITS  = 8;             // quotient bits per cycle
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_LO,
    S_SQ_HI,
    S_ADD,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_lo;
    logic sq_hi;
    logic add_term;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic div_last;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic k_last;
    logic out_free;
  } status_t;

endpackage

### rtl/core/sts_datapath.sv
`include "sine_taylor_series_macros.svh"

module sts_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  sts_pkg::cmd_t                      cmd,
  output sts_pkg::status_t                   status,
  input  logic signed [sts_pkg::ANGLE_W-1:0] angle,
  input  logic [sts_pkg::COUNT_W-1:0]        term_count,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [sts_pkg::OUT_W-1:0]   sine_value,
  output logic                               saturated
);
  import sts_pkg::*;

  logic                     neg;
  logic [ANGLE_W-1:0]       ax;
  logic [K_W-1:0]           n;
  logic [K_W-1:0]           k;
  logic [T_W-1:0]           t;
  logic [X2_W-1:0]          x2;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         divq;
  logic [D_W-1:0]           rem;
  logic [D_W-1:0]           d;
  logic signed [ACC_W-1:0]  acc;

  logic [X2_W-1:0]          mul_a;
  logic [CHUNK_W-1:0]       mul_b;
  logic [MUL_W-1:0]         mul_p;
  logic [PROD_W-1:0]        mul_sh;
  logic [PROD_W-1:0]        sq_full;
  logic [PROD_W-1:0]        rnd;
  logic [NUM_W-1:0]         divq_next;
  logic [D_W-1:0]           rem_next;
  logic [D_W-1:0]           d_next;
  logic                     minus;
  logic signed [ACC_W-1:0]  tx;
  logic [ANGLE_W-1:0]       a_mag;
  logic                     sat;
  logic signed [OUT_W-1:0]  res;

  // Shared multiplier: wide operand times one half of the narrow operand.
  always_comb begin
    if (cmd.sq_lo || cmd.sq_hi) begin
      mul_a = X2_W'(ax);
      mul_b = cmd.sq_lo ? ax[CHUNK_W-1:0] : CHUNK_W'(ax[ANGLE_W-1:CHUNK_W]);
    end else begin
      mul_a = x2;
      mul_b = cmd.mul_lo ? t[CHUNK_W-1:0] : t[T_W-1:CHUNK_W];
    end
  end

  assign mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign mul_sh  = PROD_W'({mul_p, {CHUNK_W{1'b0}}});
  assign sq_full = prod + mul_sh + (PROD_W'(1) << 31);
  // Rounding half of 2^24 and half of the divisor folded into one addend.
  assign rnd     = (PROD_W'(d >> 1) << 24) | (PROD_W'(1) << 23);
  assign d_next  = D_W'({k, 1'b0}) * D_W'({k, 1'b1});
  assign minus   = neg ^ ~k[0];
  assign tx      = $signed({{(ACC_W-T_W){1'b0}}, t});
  assign a_mag   = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);

  // Restoring division, DIV_BITS quotient bits per cycle. The remainder
  // stays below the divisor, so every step is a narrow compare.
  always_comb begin
    logic [D_W:0] r_ext;
    logic [D_W-1:0] r;
    logic [NUM_W-1:0] q;
    r = rem;
    q = divq;
    for (int i = 0; i < DIV_BITS; i++) begin
      r_ext = {r, q[NUM_W-1]};
      q = {q[NUM_W-2:0], 1'b0};
      if (r_ext >= {1'b0, d}) begin
        r_ext = r_ext - {1'b0, d};
        q[0] = 1'b1;
      end
      r = r_ext[D_W-1:0];
    end
    divq_next = q;
    rem_next  = r;
  end

  always_comb begin
    sat = !((&acc[ACC_W-1:OUT_W-1]) || ~|acc[ACC_W-1:OUT_W-1]);
    if (sat) begin
      res = acc[ACC_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      res = acc[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= angle[ANGLE_W-1];
      ax  <= a_mag;
      if ({1'b0, term_count} > (COUNT_W+1)'(MAX_TERMS)) begin
        n <= K_W'(MAX_TERMS);
      end else begin
        n <= K_W'(term_count);
      end
      k   <= K_W'(1);
      acc <= '0;
    end
    if (cmd.sq_lo) begin
      prod <= PROD_W'(mul_p);
      t    <= T_W'(({1'b0, ax} + (ANGLE_W+1)'(8)) >> 4);
    end
    if (cmd.sq_hi) begin
      x2 <= X2_W'(sq_full >> 32);
    end
    if (cmd.add_term) begin
      acc <= minus ? (acc - tx) : (acc + tx);
      d   <= d_next;
    end
    if (cmd.mul_lo) begin
      prod <= PROD_W'(mul_p) + rnd;
    end
    if (cmd.mul_hi) begin
      divq <= NUM_W'((prod + mul_sh) >> 24);
      rem  <= '0;
    end
    if (cmd.div_step) begin
      divq <= divq_next;
      rem  <= rem_next;
    end
    if (cmd.div_last) begin
      t <= T_W'(divq_next);
      k <= k + K_W'(1);
    end
    if (cmd.load_out) begin
      sine_value <= res;
      saturated  <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.n_zero   = (n == '0);
  assign status.k_last   = (k == n);
  assign status.out_free = !out_valid || !out_stall;

  `STS_ASSERT_ALWAYS(a_k_range, !cmd.add_term || (k != '0 && k <= n), "term index out of range")
  `STS_ASSERT_NEXT(a_rem_below_d, cmd.div_step, rem < d, "remainder not below divisor")
  `STS_ASSERT_ALWAYS(a_sat_limit, !(out_valid && saturated) || sine_value == OUT_MAX || sine_value == OUT_MIN, "clipped value not at a limit")

endmodule

### rtl/core/sts_controller.sv
`include "sine_taylor_series_macros.svh"

module sts_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sts_pkg::status_t  status,
  output sts_pkg::cmd_t     cmd
);
  import sts_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [DCNT_W-1:0]  cnt;
  logic               cnt_last;

  assign cnt_last = (cnt == DCNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL_HI) begin
        cnt <= '0;
      end else if (state == S_DIV) begin
        cnt <= cnt + DCNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) begin
                  state_next = S_SQ_LO;
                end
      S_SQ_LO:  state_next = S_SQ_HI;
      S_SQ_HI:  state_next = status.n_zero ? S_FINISH : S_ADD;
      S_ADD:    state_next = status.k_last ? S_FINISH : S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_DIV;
      S_DIV:    if (cnt_last) begin
                  state_next = S_ADD;
                end
      S_FINISH: if (status.out_free) begin
                  state_next = S_IDLE;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        // The input is held off while reset is applied, so no transfer is
        // taken and then dropped.
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      S_SQ_LO:  cmd.sq_lo = 1'b1;
      S_SQ_HI:  cmd.sq_hi = 1'b1;
      S_ADD:    cmd.add_term = 1'b1;
      S_MUL_LO: cmd.mul_lo = 1'b1;
      S_MUL_HI: cmd.mul_hi = 1'b1;
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = cnt_last;
      end
      S_FINISH: cmd.load_out = status.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  `STS_ASSERT_NEXT(a_accept_start, in_valid && !in_stall, state == S_SQ_LO, "item did not start")
  `STS_ASSERT_ALWAYS(a_cnt_range, state != S_DIV || cnt < DCNT_W'(DIV_STEPS), "bad divide count")
  `STS_ASSERT_ALWAYS(a_cmd_onehot,
    $onehot0({cmd.load, cmd.sq_lo, cmd.sq_hi, cmd.add_term, cmd.mul_lo, cmd.mul_hi,
              cmd.div_step, cmd.load_out}), "datapath commands overlap")

endmodule

### rtl/core/sine_taylor_series.sv
// Sine by partial Maclaurin series in fixed point.
// Input channel: in_valid / in_stall carry angle (signed Q4.28 radians) and
// term_count (number of series terms, clipped to 16). A transfer happens on
// a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry sine_value (signed Q8.24) and
// saturated, which is set when the sum was clipped to the 32-bit range.
// One item is worked on at a time. The result enters the output register as
// the controller returns to idle, and the next input transfer can be taken
// in the cycle after. Each extra term costs two passes of the shared 32 x 17
// multiplier, a full divide on the 8-bit-per-cycle divider and an accumulate
// step; the square of the angle costs two passes.
// The output register holds a finished result while the receiver stalls,
// and the block still takes and works on the next item meanwhile; it only
// waits when a second result is ready and the register is still full.
// Reset (rst, synchronous, active high) empties the output register and
// returns the controller to idle; no item in progress survives it.
module sine_taylor_series (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sts_pkg::ANGLE_W-1:0] angle,
  input  logic [sts_pkg::COUNT_W-1:0]        term_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sts_pkg::OUT_W-1:0]   sine_value,
  output logic                               saturated
);
  import sts_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t status;

  // The controller walks through square, accumulate, multiply and divide
  // steps; it takes a new item only when idle.
  sts_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the operands, the running term, the accumulator and
  // the output register with its valid flag.
  sts_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .angle      (angle),
    .term_count (term_count),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sine_value (sine_value),
    .saturated  (saturated)
  );

endmodule
